### rtl/core/cosine_similarity_assert.svh
// assertion macros for the cosine similarity block
`ifndef COSINE_SIMILARITY_ASSERT_SVH
`define COSINE_SIMILARITY_ASSERT_SVH

// same-cycle implication, held off during reset
`define CS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine_similarity check failed");

// next-cycle implication, held off during reset
`define CS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine_similarity check failed");

`endif

### rtl/core/cos_sim_pkg.sv
package cos_sim_pkg;
    localparam int ELEM_W = 16;
    localparam int ACC_W  = 48;
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int WIDE_W = 96;
    localparam int SRCH_W = 134;

    typedef logic [2:0]              t_state;
    typedef logic signed [MUL_W-1:0] t_mul_op;
endpackage

### rtl/core/cosine_similarity.sv
// channel   valid     ready     payload
// input     i_valid   o_ready   i_elem_a, i_elem_b, i_last
// output    o_valid   i_ready   o_similarity, o_zero_norm
//
// a word's three products go through the one shared 25x25 multiplier
// a last word then runs S_FIN, then the norm product and dot square on the same
// multiplier, S_INIT and a 16-step shift-and-add search for the rounded result
// reset is synchronous, active low, and clears the accumulators and handshake state
// a finished result sits in the output register; a later last word waits there
// only while that result is still not taken
module cosine_similarity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_elem_a,
    input  logic signed [15:0] i_elem_b,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_similarity,
    output logic        o_zero_norm
);
    localparam cos_sim_pkg::t_state S_IDLE = 3'd0;
    localparam cos_sim_pkg::t_state S_ACC  = 3'd1;
    localparam cos_sim_pkg::t_state S_FIN  = 3'd2;
    localparam cos_sim_pkg::t_state S_MUL  = 3'd3;
    localparam cos_sim_pkg::t_state S_INIT = 3'd4;
    localparam cos_sim_pkg::t_state S_SRCH = 3'd5;
    localparam cos_sim_pkg::t_state S_DONE = 3'd6;

    localparam int AW = cos_sim_pkg::ACC_W;
    localparam int WW = cos_sim_pkg::WIDE_W;
    localparam int SW = cos_sim_pkg::SRCH_W;

    cos_sim_pkg::t_state r_state;
    logic [3:0]  r_cnt;
    logic signed [15:0] r_a, r_b;
    logic        r_last;
    logic signed [AW-1:0] r_dot;
    logic [AW-1:0] r_na, r_nb, r_dmag;
    logic        r_neg, r_zn;
    logic [WW-1:0] r_p, r_d2;
    logic signed [SW-1:0] r_x, r_z, r_ps;
    logic [127:0] r_dd;
    logic [15:0] r_q;
    logic        r_out_valid;
    logic signed [15:0] r_sim;
    logic        r_out_zn;

    cos_sim_pkg::t_mul_op m_x, m_y;
    logic signed [cos_sim_pkg::PROD_W-1:0] m_prod;
    logic [6:0]    m_sh;
    logic [WW-1:0] m_term;
    logic signed [AW:0] dot_sum;
    logic [AW:0]   na_sum, nb_sum;
    logic signed [SW-1:0] cand, p_ext;
    logic          take;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_similarity = r_sim;
    assign o_zero_norm  = r_out_zn;

    // shared multiplier operand select
    always_comb begin
        m_x  = '0;
        m_y  = '0;
        m_sh = 7'd0;
        case (r_state)
            S_ACC: begin
                case (r_cnt[1:0])
                    2'd0: begin
                        m_x = cos_sim_pkg::t_mul_op'(r_a);
                        m_y = cos_sim_pkg::t_mul_op'(r_b);
                    end
                    2'd1: begin
                        m_x = cos_sim_pkg::t_mul_op'(r_a);
                        m_y = cos_sim_pkg::t_mul_op'(r_a);
                    end
                    default: begin
                        m_x = cos_sim_pkg::t_mul_op'(r_b);
                        m_y = cos_sim_pkg::t_mul_op'(r_b);
                    end
                endcase
            end
            S_MUL: begin
                // steps 0..3 build na*nb, steps 4..7 build dmag^2
                if (!r_cnt[2]) begin
                    m_x = {1'b0, (r_cnt[0] ? r_na[47:24] : r_na[23:0])};
                    m_y = {1'b0, (r_cnt[1] ? r_nb[47:24] : r_nb[23:0])};
                end else begin
                    m_x = {1'b0, (r_cnt[0] ? r_dmag[47:24] : r_dmag[23:0])};
                    m_y = {1'b0, (r_cnt[1] ? r_dmag[47:24] : r_dmag[23:0])};
                end
                case (r_cnt[1:0])
                    2'd0:    m_sh = 7'd0;
                    2'd3:    m_sh = 7'd48;
                    default: m_sh = 7'd24;
                endcase
            end
            default: begin
                m_x = '0;
            end
        endcase
    end

    assign m_prod  = m_x * m_y;
    assign m_term  = {48'd0, m_prod[47:0]} << m_sh;
    assign dot_sum = {r_dot[AW-1], r_dot} + m_prod[AW:0];
    assign na_sum  = {1'b0, r_na} + {1'b0, m_prod[AW-1:0]};
    assign nb_sum  = {1'b0, r_nb} + {1'b0, m_prod[AW-1:0]};

    // x = (2q-1)^2 P, z = (2q-1) P 2^(j+2), ps = P 2^(2j+2)
    assign p_ext = SW'(r_p);
    assign cand  = r_x + r_z + r_ps;
    assign take  = (cand <= $signed({6'd0, r_dd})) && !r_q[15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_out_valid <= 1'b0;
            r_sim       <= '0;
            r_out_zn    <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a     <= i_elem_a;
                        r_b     <= i_elem_b;
                        r_last  <= i_last;
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    case (r_cnt[1:0])
                        2'd0: begin
                            if (dot_sum[AW] != dot_sum[AW-1]) begin
                                r_dot <= dot_sum[AW] ? {1'b1, {(AW-1){1'b0}}}
                                                     : {1'b0, {(AW-1){1'b1}}};
                            end else begin
                                r_dot <= dot_sum[AW-1:0];
                            end
                        end
                        2'd1: r_na <= na_sum[AW] ? {AW{1'b1}} : na_sum[AW-1:0];
                        default: r_nb <= nb_sum[AW] ? {AW{1'b1}} : nb_sum[AW-1:0];
                    endcase
                    if (r_cnt[1:0] == 2'd2) begin
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                S_FIN: begin
                    r_zn   <= (r_na == '0) || (r_nb == '0);
                    r_neg  <= r_dot[AW-1];
                    r_dmag <= r_dot[AW-1] ? AW'(-r_dot) : AW'(r_dot);
                    r_q    <= '0;
                    r_p    <= '0;
                    r_d2   <= '0;
                    r_cnt  <= '0;
                    r_state <= ((r_na == '0) || (r_nb == '0)) ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    if (!r_cnt[2]) begin
                        r_p <= r_p + m_term;
                    end else begin
                        r_d2 <= r_d2 + m_term;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_x     <= p_ext;
                    r_z     <= -(p_ext <<< 17);
                    r_ps    <= p_ext <<< 32;
                    r_dd    <= {r_d2, 32'd0};
                    r_cnt   <= 4'd15;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (take) begin
                        r_x <= cand;
                        r_z <= (r_z >>> 1) + r_ps;
                        r_q <= r_q | (16'd1 << r_cnt);
                    end else begin
                        r_z <= r_z >>> 1;
                    end
                    r_ps  <= r_ps >>> 2;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_zn <= r_zn;
                        if (r_zn) begin
                            r_sim <= '0;
                        end else if (r_neg) begin
                            r_sim <= 16'(-r_q);
                        end else begin
                            r_sim <= r_q[15] ? 16'sd32767 : $signed(r_q);
                        end
                        r_dot   <= '0;
                        r_na    <= '0;
                        r_nb    <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/cos_sim_checker.sv
`include "cosine_similarity_assert.svh"

module cos_sim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_similarity,
    input logic        o_zero_norm
);
    // a result word holds until taken
    `CS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // a zero norm always reads as zero similarity
    `CS_ASSERT_NOW(a_zero_sim, i_clk, i_rst_n, o_valid && o_zero_norm, o_similarity == 16'd0)
    // the multiplier is busy right after a word is taken
    `CS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // a zero-norm result never shows the sign bit set
    `CS_ASSERT_NOW(a_no_neg_zero, i_clk, i_rst_n, o_valid && o_zero_norm, !o_similarity[15])
endmodule

bind cosine_similarity cos_sim_checker u_cos_sim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_similarity (o_similarity),
    .o_zero_norm  (o_zero_norm)
);
